/* rtl/core/greedy_box_nms_macros.svh */
// assertion macros for the greedy box suppression block
`ifndef GREEDY_BOX_NMS_MACROS_SVH
`define GREEDY_BOX_NMS_MACROS_SVH
`ifndef SYNTH
`define GBN_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GBN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GBN_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GBN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/gbn_pkg.sv */
// shared types and constants of the greedy box suppression block
package gbn_pkg;
  localparam int unsigned IdxOutW = 10;
  localparam int unsigned KeepCap = 64;
  localparam int unsigned KeepW = 7;
  localparam logic [1:0] REG_THR = 2'd0;
  localparam logic [1:0] REG_MAX = 2'd1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic store_box;   // write input item to the stores
    logic clear_box;   // reset box count to zero
    logic scan_start;  // start a maximum search pass
    logic scan_step;   // advance maximum search
    logic supp_start;  // start a suppression pass
    logic supp_step;   // advance suppression pass
    logic clr_step;    // advance flag clearing pass
    logic clr_start;   // start flag clearing pass
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic supp_done;
    logic clr_done;
    logic full;
  } stat_t;
endpackage

/* rtl/core/gbn_ram.sv */
// generic single write, single registered read memory
module gbn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/gbn_iou.sv */
// pipelined iou comparison of one box against the picked box
module gbn_iou (
  input  logic        clk,
  input  logic [63:0] box_a,
  input  logic [63:0] box_b,
  input  logic [15:0] thr,
  output logic        over
);
  logic signed [17:0] l1, t1, r1, b1, l2, t2, r2, b2;
  logic signed [17:0] ox, oy, wa, ha, wb, hb;
  logic signed [17:0] ox_q, oy_q, wa_q, ha_q, wb_q, hb_q;
  logic signed [35:0] inter_q, aa_q, ab_q;
  logic signed [37:0] uni_q;
  logic signed [36:0] inter2_q;
  logic signed [55:0] lhs, rhs_lo_q;
  logic signed [55:0] rhs;
  logic signed [37:0] uni_d;
  logic signed [36:0] inter_d;

  function automatic logic signed [17:0] ovl(input logic signed [17:0] a0,
      input logic signed [17:0] a1, input logic signed [17:0] c0,
      input logic signed [17:0] c1);
    logic signed [17:0] lo1, hi1, lo2, hi2;
    lo1 = a0; hi1 = a1; lo2 = c0; hi2 = c1;
    if (a0 > c0) begin
      lo1 = c0; hi1 = c1; lo2 = a0; hi2 = a1;
    end
    if (hi1 < lo2) return 18'sd0;
    return ((hi1 < hi2) ? hi1 : hi2) - lo2;
  endfunction

  always_comb begin
    l1 = {2'b0, box_a[15:0]};  t1 = {2'b0, box_a[31:16]};
    r1 = {2'b0, box_a[47:32]}; b1 = {2'b0, box_a[63:48]};
    l2 = {2'b0, box_b[15:0]};  t2 = {2'b0, box_b[31:16]};
    r2 = {2'b0, box_b[47:32]}; b2 = {2'b0, box_b[63:48]};
    ox = ovl(l1, r1, l2, r2);
    oy = ovl(t1, b1, t2, b2);
    wa = r1 - l1; ha = b1 - t1; wb = r2 - l2; hb = b2 - t2;
  end

  // stage 1 lengths, stage 2 products, stage 3 union, stage 4 threshold product, then a combinational compare
  always_ff @(posedge clk) begin
    ox_q <= ox; oy_q <= oy; wa_q <= wa; ha_q <= ha; wb_q <= wb; hb_q <= hb;
    inter_q <= ox_q * oy_q;
    aa_q <= wa_q * ha_q;
    ab_q <= wb_q * hb_q;
    uni_q <= 38'(aa_q) + 38'(ab_q) - 38'(inter_q);
    inter2_q <= 37'(inter_q);
    rhs_lo_q <= 56'(uni_q) * $signed({1'b0, thr});
    uni_d <= uni_q;
    inter_d <= inter2_q;
  end

  assign lhs = {{3{inter_d[36]}}, inter_d, 16'd0};
  assign rhs = rhs_lo_q;
  assign over = (uni_d == 38'sd0) ? 1'b0 : (uni_d > 0) ? (lhs > rhs) : (lhs < rhs);
endmodule

/* rtl/core/gbn_datapath.sv */
// box stores, maximum search and suppression passes
module gbn_datapath #(
  parameter int unsigned MAX_BOXES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gbn_pkg::cmd_t        cmd,
  output gbn_pkg::stat_t       stat,
  input  logic [15:0]          in_score,
  input  logic [63:0]          in_box,
  input  logic [15:0]          thr,
  output logic [gbn_pkg::IdxOutW-1:0] best_index
);
  localparam int unsigned AW = $clog2(MAX_BOXES);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam int unsigned LAT = 4;
  localparam int unsigned IdxOutW = gbn_pkg::IdxOutW;

  logic [CW-1:0] count;
  logic [AW-1:0] waddr, raddr;
  logic [CW-1:0] ptr;
  logic [15:0]   s_rd;
  logic [63:0]   c_rd;
  logic          f_rd, f_we, f_wd;
  logic [AW-1:0] f_wa, f_ra;
  logic [15:0]   best_s;
  logic [AW-1:0] best_i;
  logic [AW-1:0] kept_i;
  logic          found;
  logic [CW-1:0] rd_idx_q;
  logic          rd_v_q;
  logic [63:0]   best_box;
  logic          over;
  logic [LAT-1:0]        pv;
  logic [LAT-1:0][AW-1:0] pi;
  logic [LAT-1:0]        pf;
  logic                  scanning, supping;

  assign stat.full = (count == CW'(MAX_BOXES));
  assign waddr = count[AW-1:0];
  assign raddr = ptr[AW-1:0];

  gbn_ram #(.WIDTH(16), .DEPTH(MAX_BOXES)) u_score (
    .clk, .we(cmd.store_box && !stat.full), .waddr, .wdata(in_score), .raddr, .rdata(s_rd));
  gbn_ram #(.WIDTH(64), .DEPTH(MAX_BOXES)) u_corner (
    .clk, .we(cmd.store_box && !stat.full), .waddr, .wdata(in_box), .raddr, .rdata(c_rd));
  gbn_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_flag (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

  assign f_ra = raddr;

  gbn_iou u_iou (.clk, .box_a(c_rd), .box_b(best_box), .thr, .over);

  // box count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_box) begin
      count <= '0;
    end else if (cmd.store_box && !stat.full) begin
      count <= count + 1'b1;
    end
  end

  // read pointer walks the stored boxes for search and suppression passes, and every entry for clearing
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0; scanning <= 1'b0; supping <= 1'b0; rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= 1'b0;
      if (cmd.scan_start || cmd.supp_start || cmd.clr_start) begin
        ptr <= '0;
        scanning <= cmd.scan_start;
        supping <= cmd.supp_start;
      end else if ((cmd.scan_step || cmd.supp_step) && ptr < count) begin
        ptr <= ptr + 1'b1;
        rd_v_q <= 1'b1;
      end else if (cmd.clr_step && ptr < CW'(MAX_BOXES)) begin
        ptr <= ptr + 1'b1;
      end
      rd_idx_q <= ptr;
    end
  end

  // running maximum, lower index wins ties
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      found <= 1'b0; best_s <= '0; best_i <= '0;
    end else if (scanning && rd_v_q && !f_rd && (!found || s_rd > best_s)) begin
      found <= 1'b1; best_s <= s_rd; best_i <= rd_idx_q[AW-1:0];
    end
  end

  // picked box corners follow the running maximum
  always_ff @(posedge clk) begin
    if (scanning && rd_v_q && rd_idx_q[AW-1:0] == best_i && found) begin
      best_box <= c_rd;
    end else if (scanning && rd_v_q && !f_rd && (!found || s_rd > best_s)) begin
      best_box <= c_rd;
    end
  end

  // index of the picked box, held for the pending output item
  always_ff @(posedge clk) begin
    if (cmd.supp_start) begin
      kept_i <= best_i;
    end
  end

  // suppression result pipeline aligned to the iou unit
  always_ff @(posedge clk) begin
    if (rst || cmd.supp_start) begin
      pv <= '0;
    end else begin
      pv <= {pv[LAT-2:0], supping && rd_v_q};
      pi <= {pi[LAT-2:0], rd_idx_q[AW-1:0]};
      pf <= {pf[LAT-2:0], f_rd};
    end
  end

  // flag writes: picked box, suppressed boxes, clearing
  always_comb begin
    f_we = 1'b0; f_wa = best_i; f_wd = 1'b1;
    if (cmd.clr_step) begin
      f_we = ptr < CW'(MAX_BOXES); f_wa = raddr; f_wd = 1'b0;
    end else if (cmd.supp_start) begin
      f_we = 1'b1;
    end else if (pv[LAT-1] && !pf[LAT-1] && over) begin
      f_we = 1'b1; f_wa = pi[LAT-1];
    end
  end

  assign stat.found = found;
  assign stat.scan_done = scanning && ptr == count && !rd_v_q;
  assign stat.supp_done = supping && ptr == count && !rd_v_q && pv == '0;
  assign stat.clr_done = ptr == CW'(MAX_BOXES);
  assign best_index = IdxOutW'(kept_i);

  `include "greedy_box_nms_macros.svh"
  `GBN_ASSERT_IMPL(a_cnt_max, clk, rst, 1'b1, count <= CW'(MAX_BOXES))
  `GBN_ASSERT_IMPL(a_one_pass, clk, rst, 1'b1, !(scanning && supping))
  `GBN_ASSERT_NEXT(a_full_hold, clk, rst, stat.full && !cmd.clear_box, stat.full)
endmodule

/* rtl/core/gbn_ctrl.sv */
// sequencer of load, search, emit, suppress and clear phases
module gbn_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic                 in_last,
  input  logic                 out_ready,
  input  logic [gbn_pkg::KeepW-1:0] max_kept,
  input  gbn_pkg::stat_t       stat,
  output gbn_pkg::cmd_t        cmd,
  output logic                 in_ready,
  output logic                 out_valid,
  output logic                 out_last
);
  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_SUPP = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;

  logic [2:0] state, state_next;
  logic [gbn_pkg::KeepW-1:0] kept, limit;
  logic pend, pend_next;

  assign limit = (max_kept > gbn_pkg::KeepW'(gbn_pkg::KeepCap)) ?
                 gbn_pkg::KeepW'(gbn_pkg::KeepCap) : max_kept;
  assign in_ready = (state == S_LOAD);

  // held result: out_valid stays until taken, last flag decided after next search or once the limit is reached
  always_comb begin
    cmd = '0; state_next = state; pend_next = pend;
    out_valid = 1'b0; out_last = 1'b0;
    case (state)
      S_LOAD: begin
        cmd.store_box = in_fire;
        if (in_fire && in_last) begin
          if (limit == '0) begin
            state_next = S_CLR; cmd.clr_start = 1'b1;
          end else begin
            state_next = S_SCAN; cmd.scan_start = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (pend) begin
          out_valid = 1'b1;
          out_last = !stat.found || kept == limit;
          if (out_ready) begin
            pend_next = 1'b0;
            if (out_last) begin
              state_next = S_CLR; cmd.clr_start = 1'b1;
            end else begin
              state_next = S_SUPP; cmd.supp_start = 1'b1;
            end
          end
        end else if (!stat.found) begin
          state_next = S_CLR; cmd.clr_start = 1'b1;
        end else begin
          state_next = S_SUPP; cmd.supp_start = 1'b1;
        end
      end
      S_SUPP: begin
        cmd.supp_step = 1'b1;
        if (stat.supp_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        pend_next = 1'b1;
        if (kept == limit) begin
          state_next = S_EVAL;
        end else begin
          state_next = S_SCAN; cmd.scan_start = 1'b1;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_next = S_LOAD; cmd.clear_box = 1'b1;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // state, pending flag and kept count; reset starts with a flag clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; pend <= 1'b0; kept <= '0;
    end else begin
      state <= state_next; pend <= pend_next;
      if (state == S_LOAD) kept <= '0;
      else if (cmd.supp_start) kept <= kept + 1'b1;
    end
  end

  `include "greedy_box_nms_macros.svh"
  `GBN_ASSERT_IMPL(a_kept_lim, clk, rst, 1'b1, kept <= limit)
  `GBN_ASSERT_IMPL(a_out_only_eval, clk, rst, out_valid, state == S_EVAL)
  `GBN_ASSERT_NEXT(a_ld_after_clr, clk, rst, state == S_CLR && stat.clr_done,
                   state == S_LOAD)
endmodule

/* rtl/core/greedy_box_nms.sv */
// greedy box suppression: loads boxes, emits kept indices in score order
// loading: one item per cycle, results none until the last box
// search: one pass per kept box, one stored box read a cycle
// suppression: one pass per kept box through the iou pipeline
// end of run: a flag clearing pass over all MAX_BOXES flags, no item taken then
// reset: synchronous, empties the set, restores defaults, then the same clearing pass
module greedy_box_nms #(
  parameter int unsigned MAX_BOXES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // score, left, top, right, bottom
  input  logic        s_tlast,  // last_box
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // kept_index
  output logic        m_tlast,  // last_kept
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] thr;
  logic [gbn_pkg::KeepW-1:0] max_kept;
  gbn_pkg::cmd_t  cmd;
  gbn_pkg::stat_t stat;
  logic [gbn_pkg::IdxOutW-1:0] best_index;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 16'd32768; max_kept <= 7'd64;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == gbn_pkg::REG_THR[0]) thr <= pwdata[15:0];
      else max_kept <= pwdata[6:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == gbn_pkg::REG_MAX[0]) prdata = {25'd0, max_kept};
    else prdata = {16'd0, thr};
  end

  gbn_ctrl u_ctrl (.clk, .rst, .in_fire(s_tvalid && s_tready), .in_last(s_tlast),
    .out_ready(m_tready), .max_kept, .stat, .cmd, .in_ready(s_tready),
    .out_valid(m_tvalid), .out_last(m_tlast));

  gbn_datapath #(.MAX_BOXES(MAX_BOXES)) u_dp (.clk, .rst, .cmd, .stat,
    .in_score(s_tdata[15:0]), .in_box(s_tdata[79:16]), .thr, .best_index);

  assign m_tdata = {6'd0, best_index};
endmodule
